// ===== hw/rtl/fpt_pkg.sv =====
// shared types, codes and reset constants for the frame point transform
`default_nettype none

package fpt_pkg;

  // item kind codes
  localparam logic [1:0] KIND_W2L_POINT  = 2'd0;
  localparam logic [1:0] KIND_L2W_POINT  = 2'd1;
  localparam logic [1:0] KIND_W2L_VECTOR = 2'd2;
  localparam logic [1:0] KIND_L2W_VECTOR = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z   = 3'd5;

  // widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned VEC_W   = 33;
  localparam int unsigned COEF_W  = 18;
  localparam int unsigned AXIS_W  = 3 * COEF_W;
  localparam int unsigned PROD_W  = VEC_W + COEF_W;
  localparam int unsigned SUM_W   = 54;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned RND_W   = SUM_W - FRAC_W;

  // reset axes: identity frame
  localparam logic [AXIS_W-1:0] AXIS_X_RST = 54'd65536;
  localparam logic [AXIS_W-1:0] AXIS_Y_RST = 54'd65536 << COEF_W;
  localparam logic [AXIS_W-1:0] AXIS_Z_RST = 54'd65536 << (2 * COEF_W);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // input item
  typedef struct packed {
    logic [1:0] kind;
    coord_t     in_x;
    coord_t     in_y;
    coord_t     in_z;
    logic       zero_z;
  } in_item_t;

  // result item
  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   overflow;
  } out_item_t;

  // control that travels with an item down the pipe
  typedef struct packed {
    logic valid;
    logic zero_out_z;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpt_operand.sv =====
// operand stage: origin difference, coefficient routing and input register
`default_nettype none

module fpt_operand (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             load,
  input  wire fpt_pkg::in_item_t                item,
  input  wire fpt_pkg::coord_t [2:0]            origin,
  input  wire logic [2:0][fpt_pkg::AXIS_W-1:0]  axis,
  output fpt_pkg::stage_ctl_t                   ctl_r,
  output fpt_pkg::vec_t [2:0]                   vec_r,
  output fpt_pkg::coef_t [2:0][2:0]             coef_r,
  output fpt_pkg::coord_t [2:0]                 org_r
);

  logic                             to_local;
  logic                             point;
  fpt_pkg::coord_t [2:0]            in_v;
  fpt_pkg::vec_t [2:0]              vec_nxt;
  fpt_pkg::coef_t [2:0][2:0]        coef_nxt;
  fpt_pkg::coord_t [2:0]            org_nxt;
  fpt_pkg::stage_ctl_t              ctl_nxt;

  // kind decode
  assign to_local = (item.kind == fpt_pkg::KIND_W2L_POINT) ||
                    (item.kind == fpt_pkg::KIND_W2L_VECTOR);
  assign point    = (item.kind == fpt_pkg::KIND_W2L_POINT) ||
                    (item.kind == fpt_pkg::KIND_L2W_POINT);

  assign in_v[0] = item.in_x;
  assign in_v[1] = item.in_y;
  assign in_v[2] = item.in_z;

  // exact 33-bit difference for world-to-local points, origin term for local-to-world points
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (to_local && point) begin
        vec_nxt[i] = fpt_pkg::vec_t'(in_v[i]) - fpt_pkg::vec_t'(origin[i]);
      end else begin
        vec_nxt[i] = fpt_pkg::vec_t'(in_v[i]);
      end
      org_nxt[i] = (!to_local && point) ? origin[i] : '0;
    end
  end

  // coefficient for row r, column c: axis r slot c, or transposed
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (to_local) begin
          coef_nxt[r][c] = axis[r][c*fpt_pkg::COEF_W +: fpt_pkg::COEF_W];
        end else begin
          coef_nxt[r][c] = axis[c][r*fpt_pkg::COEF_W +: fpt_pkg::COEF_W];
        end
      end
    end
  end

  assign ctl_nxt.valid      = load;
  assign ctl_nxt.zero_out_z = to_local && item.zero_z;

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      vec_r  <= vec_nxt;
      coef_r <= coef_nxt;
      org_r  <= org_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fpt_mult.sv =====
// product stage: nine 33x18 signed products, registered
`default_nettype none

module fpt_mult (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fpt_pkg::stage_ctl_t         ctl,
  input  wire fpt_pkg::vec_t [2:0]         vec,
  input  wire fpt_pkg::coef_t [2:0][2:0]   coef,
  input  wire fpt_pkg::coord_t [2:0]       org,
  output fpt_pkg::stage_ctl_t              ctl_r,
  output fpt_pkg::prod_t [2:0][2:0]        prod_r,
  output fpt_pkg::coord_t [2:0]            org_r
);

  fpt_pkg::prod_t [2:0][2:0] prod_nxt;

  // one product per row and column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = $signed(vec[c]) * $signed(coef[r][c]);
      end
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prod_r <= prod_nxt;
      org_r  <= org;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fpt_finish.sv =====
// result stage: row sums, round to Q16.16, saturate, result register
`default_nettype none

module fpt_finish (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fpt_pkg::stage_ctl_t         ctl,
  input  wire fpt_pkg::prod_t [2:0][2:0]   prod,
  input  wire fpt_pkg::coord_t [2:0]       org,
  output logic                             out_valid_r,
  output fpt_pkg::out_item_t               out_item_r
);

  logic signed [fpt_pkg::SUM_W-1:0]  sum     [3];
  logic signed [fpt_pkg::SUM_W-1:0]  rnd     [3];
  logic signed [fpt_pkg::RND_W-1:0]  shifted [3];
  fpt_pkg::coord_t [2:0]             sat;
  logic [2:0]                        ovf;
  fpt_pkg::out_item_t                out_item_nxt;

  // sum, round half up, clamp
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = fpt_pkg::SUM_W'(prod[r][0]) + fpt_pkg::SUM_W'(prod[r][1]) +
               fpt_pkg::SUM_W'(prod[r][2]) +
               (fpt_pkg::SUM_W'(org[r]) <<< fpt_pkg::FRAC_W);
      rnd[r] = sum[r] + fpt_pkg::SUM_W'(1 << (fpt_pkg::FRAC_W - 1));
      shifted[r] = fpt_pkg::RND_W'(rnd[r] >>> fpt_pkg::FRAC_W);
      ovf[r] = (shifted[r][fpt_pkg::RND_W-1:fpt_pkg::COORD_W-1] != '0) &&
               (shifted[r][fpt_pkg::RND_W-1:fpt_pkg::COORD_W-1] != '1);
      if (ovf[r]) begin
        sat[r] = shifted[r][fpt_pkg::RND_W-1] ? {1'b1, {(fpt_pkg::COORD_W-1){1'b0}}}
                                              : {1'b0, {(fpt_pkg::COORD_W-1){1'b1}}};
      end else begin
        sat[r] = shifted[r][fpt_pkg::COORD_W-1:0];
      end
    end
  end

  // forced zero z hides its saturation
  always_comb begin
    out_item_nxt.out_x = sat[0];
    out_item_nxt.out_y = sat[1];
    out_item_nxt.out_z = ctl.zero_out_z ? '0 : sat[2];
    out_item_nxt.overflow = ovf[0] || ovf[1] || (ovf[2] && !ctl.zero_out_z);
  end

  // strobe register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/frame_point_transform_core.sv =====
// top level of the frame point transform: config registers and three-stage pipe
//
//   channel   ports                           handshake
//   input     start, busy, in_item            start high, busy low at clk edge
//   result    out_valid, out_item             one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_index, cfg_data     write when cfg_we high
//
// one item per cycle; busy is held low, the pipe never stops
// each item passes in turn the operand register, product register, result register
// the product stage (nine 33x18 signed multipliers) sets the clock rate
// reset clears the stage valids and loads the identity frame at the origin
// results are never held back, so nothing in the pipe stalls
`default_nettype none

module frame_point_transform_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire fpt_pkg::in_item_t                 in_item,
  output logic                                   out_valid,
  output fpt_pkg::out_item_t                     out_item,
  input  wire logic                              cfg_we,
  input  wire logic [fpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fpt_pkg::AXIS_W-1:0]        cfg_data
);

  fpt_pkg::coord_t [2:0]                origin_r;
  logic [2:0][fpt_pkg::AXIS_W-1:0]      axis_r;
  logic                                 in_fire;

  fpt_pkg::stage_ctl_t                  s1_ctl;
  fpt_pkg::vec_t [2:0]                  s1_vec;
  fpt_pkg::coef_t [2:0][2:0]            s1_coef;
  fpt_pkg::coord_t [2:0]                s1_org;
  fpt_pkg::stage_ctl_t                  s2_ctl;
  fpt_pkg::prod_t [2:0][2:0]            s2_prod;
  fpt_pkg::coord_t [2:0]                s2_org;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r  <= '0;
      axis_r[0] <= fpt_pkg::AXIS_X_RST;
      axis_r[1] <= fpt_pkg::AXIS_Y_RST;
      axis_r[2] <= fpt_pkg::AXIS_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpt_pkg::CFG_ORIGIN_X: origin_r[0] <= cfg_data[fpt_pkg::COORD_W-1:0];
        fpt_pkg::CFG_ORIGIN_Y: origin_r[1] <= cfg_data[fpt_pkg::COORD_W-1:0];
        fpt_pkg::CFG_ORIGIN_Z: origin_r[2] <= cfg_data[fpt_pkg::COORD_W-1:0];
        fpt_pkg::CFG_AXIS_X:   axis_r[0]   <= cfg_data;
        fpt_pkg::CFG_AXIS_Y:   axis_r[1]   <= cfg_data;
        fpt_pkg::CFG_AXIS_Z:   axis_r[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand stage
  fpt_operand u_operand (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_fire),
    .item   (in_item),
    .origin (origin_r),
    .axis   (axis_r),
    .ctl_r  (s1_ctl),
    .vec_r  (s1_vec),
    .coef_r (s1_coef),
    .org_r  (s1_org)
  );

  // product stage
  fpt_mult u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (s1_ctl),
    .vec    (s1_vec),
    .coef   (s1_coef),
    .org    (s1_org),
    .ctl_r  (s2_ctl),
    .prod_r (s2_prod),
    .org_r  (s2_org)
  );

  // result stage
  fpt_finish u_finish (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (s2_ctl),
    .prod        (s2_prod),
    .org         (s2_org),
    .out_valid_r (out_valid),
    .out_item_r  (out_item)
  );

  // every accepted item produces a result while reset stays high
  a_item_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_fire && rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)) |-> out_valid)
    else $error("accepted item did not produce a result");

  // no result without an accepted item
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, 3))
    else $error("result without an accepted item");

  // forced zero z in world-to-local modes
  a_zero_z: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_fire && rst_n && in_item.zero_z &&
           ((in_item.kind == fpt_pkg::KIND_W2L_POINT) ||
            (in_item.kind == fpt_pkg::KIND_W2L_VECTOR)), 3) &&
     $past(rst_n, 2) && $past(rst_n, 1)) |-> (out_item.out_z == '0))
    else $error("z not cleared");

  // overflow only with a component at a clamp limit
  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.overflow) |->
      ((out_item.out_x == 32'sh7FFF_FFFF) || (out_item.out_x == 32'sh8000_0000) ||
       (out_item.out_y == 32'sh7FFF_FFFF) || (out_item.out_y == 32'sh8000_0000) ||
       (out_item.out_z == 32'sh7FFF_FFFF) || (out_item.out_z == 32'sh8000_0000)))
    else $error("overflow without a clamped component");

endmodule

`default_nettype wire

// ===== test/frame_point_transform_core_tb.sv =====
// self-checking testbench for the frame point transform core
`timescale 1ns / 1ps

module frame_point_transform_core_tb;

  localparam int PIPE_LAT = 3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 243;

  localparam fpt_pkg::coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam fpt_pkg::coord_t COORD_MIN = 32'sh8000_0000;
  localparam fpt_pkg::coef_t COEF_MAX = 18'sh1FFFF;
  localparam fpt_pkg::coef_t COEF_MIN = 18'sh20000;
  localparam fpt_pkg::coef_t COEF_ONE = 18'sh10000;
  localparam fpt_pkg::coef_t COEF_HALF = 18'sh08000;
  localparam fpt_pkg::coef_t COEF_ZERO = 18'sh00000;

  // index values past the last register, writes there must change nothing
  localparam logic [fpt_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [fpt_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // frame copy, transform predictor and queue of predicted results
  class point_result_board;
    fpt_pkg::coord_t origin [3];
    logic [fpt_pkg::AXIS_W-1:0] axis [3];
    fpt_pkg::out_item_t pending_points [$];
    int unsigned errors;

    function new();
      for (int i = 0; i < 3; i++) origin[i] = '0;
      axis[0] = fpt_pkg::AXIS_X_RST;
      axis[1] = fpt_pkg::AXIS_Y_RST;
      axis[2] = fpt_pkg::AXIS_Z_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [fpt_pkg::CFG_IDX_W-1:0] idx,
                            logic [fpt_pkg::AXIS_W-1:0] data);
      case (idx)
        fpt_pkg::CFG_ORIGIN_X: origin[0] = data[fpt_pkg::COORD_W-1:0];
        fpt_pkg::CFG_ORIGIN_Y: origin[1] = data[fpt_pkg::COORD_W-1:0];
        fpt_pkg::CFG_ORIGIN_Z: origin[2] = data[fpt_pkg::COORD_W-1:0];
        fpt_pkg::CFG_AXIS_X: axis[0] = data;
        fpt_pkg::CFG_AXIS_Y: axis[1] = data;
        fpt_pkg::CFG_AXIS_Z: axis[2] = data;
        default: ;
      endcase
    endfunction

    // component k of axis a
    function fpt_pkg::coef_t coef(int a, int k);
      return axis[a][fpt_pkg::COEF_W*k +: fpt_pkg::COEF_W];
    endfunction

    // Q32.32 sum to Q16.16, ties toward plus infinity, then clamp
    function fpt_pkg::coord_t round_sat(input longint sum, inout bit ovf);
      longint r;
      r = (sum + 64'sd32768) >>> fpt_pkg::FRAC_W;
      if (r > longint'(COORD_MAX)) begin
        ovf = 1'b1;
        return COORD_MAX;
      end
      if (r < longint'(COORD_MIN)) begin
        ovf = 1'b1;
        return COORD_MIN;
      end
      return fpt_pkg::coord_t'(r);
    endfunction

    function fpt_pkg::out_item_t map_point(fpt_pkg::in_item_t it);
      longint v [3];
      longint sum [3];
      bit to_local;
      bit is_point;
      bit ovf;
      fpt_pkg::out_item_t r;
      v[0] = longint'(it.in_x);
      v[1] = longint'(it.in_y);
      v[2] = longint'(it.in_z);
      to_local = (it.kind == fpt_pkg::KIND_W2L_POINT) ||
                 (it.kind == fpt_pkg::KIND_W2L_VECTOR);
      is_point = (it.kind == fpt_pkg::KIND_W2L_POINT) ||
                 (it.kind == fpt_pkg::KIND_L2W_POINT);
      ovf = 1'b0;
      if (to_local) begin
        // exact 33-bit difference, then dot product with each axis
        if (is_point)
          for (int i = 0; i < 3; i++) v[i] = v[i] - longint'(origin[i]);
        for (int j = 0; j < 3; j++) begin
          sum[j] = 0;
          for (int i = 0; i < 3; i++) sum[j] += v[i] * longint'(coef(j, i));
        end
      end else begin
        // weighted sum of axes, origin added for points
        for (int i = 0; i < 3; i++) begin
          sum[i] = is_point ? (longint'(origin[i]) <<< fpt_pkg::FRAC_W) : 64'sd0;
          for (int j = 0; j < 3; j++) sum[i] += longint'(coef(j, i)) * v[j];
        end
      end
      r.out_x = round_sat(sum[0], ovf);
      r.out_y = round_sat(sum[1], ovf);
      if (to_local && it.zero_z)
        r.out_z = '0;
      else
        r.out_z = round_sat(sum[2], ovf);
      r.overflow = ovf;
      return r;
    endfunction

    function void note_item(fpt_pkg::in_item_t it);
      pending_points.insert(pending_points.size(), map_point(it));
    endfunction

    function void check_result(fpt_pkg::out_item_t got);
      fpt_pkg::out_item_t want;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d ovf=%0b", $time,
                 got.out_x, got.out_y, got.out_z, got.overflow);
        errors++;
        return;
      end
      want = pending_points.pop_front();
      if (got.out_x !== want.out_x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, want.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== want.out_y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, want.out_y, got.out_y);
        errors++;
      end
      if (got.out_z !== want.out_z) begin
        $display("%0t: out_z expected %0d actual %0d", $time, want.out_z, got.out_z);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                 got.overflow);
        errors++;
      end
    endfunction

    function int pending();
      return pending_points.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  fpt_pkg::in_item_t in_item = '0;
  logic cfg_we = 1'b0;
  logic [fpt_pkg::CFG_IDX_W-1:0] cfg_index = fpt_pkg::CFG_ORIGIN_X;
  logic [fpt_pkg::AXIS_W-1:0] cfg_data = '0;
  logic busy;
  logic out_valid;
  fpt_pkg::out_item_t out_item;
  int cycles = 0;

  point_result_board board = new();

  frame_point_transform_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watch all three ports at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.write_reg(cfg_index, cfg_data);
      if (start && !busy) board.note_item(in_item);
      if (out_valid) board.check_result(out_item);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("frame_point_transform_core_tb NOT OK");
      $finish;
    end
  end

  function automatic fpt_pkg::in_item_t mk_item(logic [1:0] kind, fpt_pkg::coord_t x,
                                                fpt_pkg::coord_t y, fpt_pkg::coord_t z,
                                                logic zz);
    fpt_pkg::in_item_t it;
    it.kind = kind;
    it.in_x = x;
    it.in_y = y;
    it.in_z = z;
    it.zero_z = zz;
    return it;
  endfunction

  function automatic logic [fpt_pkg::AXIS_W-1:0] pack_axis(fpt_pkg::coef_t cx,
                                                           fpt_pkg::coef_t cy,
                                                           fpt_pkg::coef_t cz);
    return {cz, cy, cx};
  endfunction

  function automatic fpt_pkg::coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return fpt_pkg::coord_t'(int'($urandom_range(0, 6)) - 3);
      3, 4: return fpt_pkg::coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
      default: return fpt_pkg::coord_t'($urandom());
    endcase
  endfunction

  function automatic fpt_pkg::coef_t rand_coef();
    case ($urandom_range(0, 7))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return COEF_ONE;
      3: return -COEF_ONE;
      4: return COEF_ZERO;
      5: return fpt_pkg::coef_t'(int'($urandom_range(0, 64)) - 32);
      default: return fpt_pkg::coef_t'($urandom());
    endcase
  endfunction

  function automatic fpt_pkg::in_item_t rand_item();
    return mk_item(2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord(),
                   1'($urandom_range(0, 1)));
  endfunction

  // one register write, enable stays high for the next one
  task automatic put_reg(logic [fpt_pkg::CFG_IDX_W-1:0] idx,
                         logic [fpt_pkg::AXIS_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // whole frame, junk in the unused high bits of the origin writes
  task automatic load_frame(fpt_pkg::coord_t ox, fpt_pkg::coord_t oy, fpt_pkg::coord_t oz,
                            logic [fpt_pkg::AXIS_W-1:0] ax,
                            logic [fpt_pkg::AXIS_W-1:0] ay,
                            logic [fpt_pkg::AXIS_W-1:0] az);
    put_reg(fpt_pkg::CFG_ORIGIN_X, {22'($urandom()), ox});
    put_reg(fpt_pkg::CFG_ORIGIN_Y, {22'($urandom()), oy});
    put_reg(fpt_pkg::CFG_ORIGIN_Z, {22'($urandom()), oz});
    put_reg(fpt_pkg::CFG_AXIS_X, ax);
    put_reg(fpt_pkg::CFG_AXIS_Y, ay);
    put_reg(fpt_pkg::CFG_AXIS_Z, az);
    if ($urandom_range(0, 1))
      put_reg(CFG_SPARE_LO, fpt_pkg::AXIS_W'({$urandom(), $urandom()}));
    if ($urandom_range(0, 1))
      put_reg(CFG_SPARE_HI, fpt_pkg::AXIS_W'({$urandom(), $urandom()}));
    cfg_we <= 1'b0;
  endtask

  // start stays high when the next item follows with no gap
  task automatic send_item(fpt_pkg::in_item_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and let the pipe empty
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic run_random(int count);
    int burst;
    int gap;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      if (burst > 0) begin
        gap = 0;
        burst--;
      end else if ($urandom_range(0, 15) == 0) begin
        gap = 0;
        burst = $urandom_range(10, 40);
      end else begin
        gap = $urandom_range(0, 10);
      end
      send_item(rand_item(), gap);
    end
    drain();
  endtask

  // main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity frame out of reset: extremes, every kind, zero_z both ways
    send_item(mk_item(fpt_pkg::KIND_W2L_POINT, COORD_MAX, COORD_MIN, 0, 1'b0), 0);
    send_item(mk_item(fpt_pkg::KIND_L2W_POINT, COORD_MIN, COORD_MAX, -1, 1'b1), 0);
    send_item(mk_item(fpt_pkg::KIND_W2L_VECTOR, 1, -1, 12345, 1'b1), 1);
    send_item(mk_item(fpt_pkg::KIND_L2W_VECTOR, 0, 0, 0, 1'b0), 0);
    send_item(mk_item(fpt_pkg::KIND_W2L_POINT, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1), 2);
    drain();

    // extreme origin and coefficients, half for the rounding ties
    load_frame(COORD_MAX, COORD_MIN, 1,
               pack_axis(COEF_MIN, COEF_MAX, COEF_ZERO),
               pack_axis(COEF_HALF, COEF_ZERO, COEF_ZERO),
               pack_axis(COEF_ZERO, COEF_ZERO, COEF_MIN));
    // saturating difference, with and without forced zero
    send_item(mk_item(fpt_pkg::KIND_W2L_POINT, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0), 0);
    send_item(mk_item(fpt_pkg::KIND_W2L_POINT, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1), 0);
    // only z saturates: forced zero hides it from overflow
    send_item(mk_item(fpt_pkg::KIND_W2L_VECTOR, 0, 0, COORD_MIN, 1'b1), 0);
    send_item(mk_item(fpt_pkg::KIND_W2L_VECTOR, 0, 0, COORD_MIN, 1'b0), 1);
    // half-lsb ties on both signs
    send_item(mk_item(fpt_pkg::KIND_W2L_VECTOR, 1, 0, 0, 1'b0), 0);
    send_item(mk_item(fpt_pkg::KIND_W2L_VECTOR, -1, 0, 0, 1'b0), 0);
    send_item(mk_item(fpt_pkg::KIND_L2W_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0), 3);
    send_item(mk_item(fpt_pkg::KIND_L2W_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1), 0);
    send_item(mk_item(fpt_pkg::KIND_L2W_VECTOR, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0), 0);
    send_item(mk_item(fpt_pkg::KIND_L2W_VECTOR, 1, -1, 0, 1'b1), 0);
    drain();

    // random phases over several frames
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: load_frame(0, 0, 0, fpt_pkg::AXIS_X_RST, fpt_pkg::AXIS_Y_RST,
                      fpt_pkg::AXIS_Z_RST);
        1: load_frame(COORD_MIN, COORD_MIN, COORD_MIN,
                      pack_axis(COEF_MAX, COEF_MAX, COEF_MAX),
                      pack_axis(COEF_MAX, COEF_MAX, COEF_MAX),
                      pack_axis(COEF_MAX, COEF_MAX, COEF_MAX));
        2: load_frame(COORD_MAX, COORD_MAX, COORD_MAX,
                      pack_axis(COEF_MIN, COEF_MIN, COEF_MIN),
                      pack_axis(COEF_MIN, COEF_MIN, COEF_MIN),
                      pack_axis(COEF_MIN, COEF_MIN, COEF_MIN));
        default: load_frame(rand_coord(), rand_coord(), rand_coord(),
                            pack_axis(rand_coef(), rand_coef(), rand_coef()),
                            pack_axis(rand_coef(), rand_coef(), rand_coef()),
                            pack_axis(rand_coef(), rand_coef(), rand_coef()));
      endcase
      run_random(ITEMS_PER_PHASE);
    end

    if (board.errors == 0 && board.pending() == 0)
      $display("frame_point_transform_core_tb OK");
    else
      $display("frame_point_transform_core_tb NOT OK");
    $finish;
  end

endmodule

// ===== frame_point_transform_core.f =====
hw/rtl/fpt_pkg.sv
hw/rtl/fpt_operand.sv
hw/rtl/fpt_mult.sv
hw/rtl/fpt_finish.sv
hw/rtl/frame_point_transform_core.sv
test/frame_point_transform_core_tb.sv
